// ===== hw/rtl/ipfl_pkg.sv =====
package ipfl_pkg;

	// Default configuration of the pool.
	localparam int unsigned POOL_DEPTH_DEF = 1024;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Fixed widths of the transaction fields.
	localparam int unsigned OP_W     = 3;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 11;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 3'd0,
		OP_DUP   = 3'd1,
		OP_FREE  = 3'd2,
		OP_READ  = 3'd3,
		OP_WRITE = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ipfl_cmd_t;

endpackage

// ===== hw/rtl/indexed_pool_free_list.sv =====
// Indexed pool allocator with a LIFO free list. Each transaction (add, dup,
// free, read, write, clear) is accepted, then executed: the cycle in which
// start is accepted registers the operation and issues the synchronous reads
// of the payload, valid and free-list link memories, and the following cycle
// (busy high) executes the operation and writes the memories. The result
// appears on status, slot, read_data and live_count after execution, marked
// by done, which is high for exactly one cycle; the receiver cannot stall it.
// start may be accepted again in that same cycle but not while busy, as the
// free-list head link read precedes each allocation. Slot validity is
// qualified by the high-water mark, so reset and clear need no sweep of the
// pool. empty_value is written through cfg_valid/cfg_data, always ready, and
// must only be written while no transaction is in progress.
module indexed_pool_free_list #(
	parameter int unsigned POOL_DEPTH = ipfl_pkg::POOL_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ipfl_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ipfl_pkg::OP_W-1:0]     operation,
	input  logic [ipfl_pkg::IDX_W-1:0]    index,
	input  logic [ipfl_pkg::WORD_W-1:0]   data,
	output logic                          done,
	output logic [ipfl_pkg::STATUS_W-1:0] status,
	output logic [ipfl_pkg::IDX_W-1:0]    slot,
	output logic [ipfl_pkg::WORD_W-1:0]   read_data,
	output logic [ipfl_pkg::COUNT_W-1:0]  live_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipfl_pkg::WORD_W-1:0]   cfg_data
);
	import ipfl_pkg::*;

	ipfl_cmd_t cmd;

	// The configuration register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	ipfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ipfl_dp #(
		.POOL_DEPTH (POOL_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (operation),
		.index      (index),
		.data       (data),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.status     (status),
		.slot       (slot),
		.read_data  (read_data),
		.live_count (live_count)
	);

endmodule

// ===== hw/rtl/ipfl_ctrl.sv =====
module ipfl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output ipfl_pkg::ipfl_cmd_t cmd
);
	import ipfl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// Commands: capture in the idle state, execute in the following cycle.
	assign busy     = (state_q == S_EXEC);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
	assign done     = done_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

`ifndef SYNTHESIS
	// An accepted transaction is executed in the next cycle.
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted transaction was not executed");

	// Every execution cycle is followed by exactly one result strobe.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (done && !cmd.exec))
		else $error("execution not followed by a single result strobe");
`endif

endmodule

// ===== hw/rtl/ipfl_dp.sv =====
module ipfl_dp #(
	parameter int unsigned POOL_DEPTH = ipfl_pkg::POOL_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ipfl_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ipfl_pkg::ipfl_cmd_t             cmd,
	input  logic [ipfl_pkg::OP_W-1:0]       operation,
	input  logic [ipfl_pkg::IDX_W-1:0]      index,
	input  logic [ipfl_pkg::WORD_W-1:0]     data,
	input  logic                            cfg_we,
	input  logic [ipfl_pkg::WORD_W-1:0]     cfg_data,
	output logic [ipfl_pkg::STATUS_W-1:0]   status,
	output logic [ipfl_pkg::IDX_W-1:0]      slot,
	output logic [ipfl_pkg::WORD_W-1:0]     read_data,
	output logic [ipfl_pkg::COUNT_W-1:0]    live_count
);
	import ipfl_pkg::*;

	localparam int unsigned AW = $clog2(POOL_DEPTH);
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

	// Pool memories: payload, free-list link and valid flag per slot.
	logic [DATA_WIDTH-1:0] pay_mem  [POOL_DEPTH];
	logic [CW-1:0]         link_mem [POOL_DEPTH];
	logic                  vld_mem  [POOL_DEPTH];

	// Captured transaction and registered memory reads.
	op_t                   op_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [DATA_WIDTH-1:0] pay_rd_q;
	logic [CW-1:0]         link_rd_q;
	logic                  vld_rd_q;

	// Pool state.
	logic [CW-1:0]         hw_q, hw_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [AW-1:0]         fh_q, fh_d;
	logic                  fhv_q, fhv_d;
	logic [WORD_W-1:0]     empty_q;

	// Result registers.
	logic [STATUS_W-1:0]   status_q;
	logic [IDX_W-1:0]      slot_q;
	logic [WORD_W-1:0]     read_data_q;
	logic [COUNT_W-1:0]    live_count_q;

	// Execute-cycle signals.
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         idx_addr;
	logic                  src_live;
	logic                  can_take;
	logic                  link_ok;
	logic [AW-1:0]         take_slot;
	logic                  pay_we;
	logic [AW-1:0]         pay_wa;
	logic [DATA_WIDTH-1:0] pay_wd;
	logic                  vld_we;
	logic [AW-1:0]         vld_wa;
	logic                  vld_wd;
	logic                  link_we;
	logic [CW-1:0]         link_wd;
	status_t               status_d;
	logic [IDX_W-1:0]      slot_d;
	logic [WORD_W-1:0]     rd_d;

	assign rd_addr  = AW'(index);
	assign idx_addr = AW'(idx_s1);

	// Capture the transaction and start the synchronous memory reads.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1     <= op_t'(operation);
			idx_s1    <= index;
			data_s1   <= DATA_WIDTH'(data);
			pay_rd_q  <= pay_mem[rd_addr];
			vld_rd_q  <= vld_mem[rd_addr];
			link_rd_q <= link_mem[fh_q];
		end
	end

	// A slot is live only below the high-water mark, so clear needs no sweep:
	// entries above the mark are stale and never trusted.
	assign src_live  = (32'(idx_s1) < 32'(hw_q)) && vld_rd_q;
	assign can_take  = fhv_q || (hw_q < CW'(POOL_DEPTH));
	assign take_slot = fhv_q ? fh_q : AW'(hw_q);
	assign link_ok   = (link_rd_q < CW'(POOL_DEPTH));

	// Operation decode and next state.
	always_comb begin
		hw_d     = hw_q;
		cnt_d    = cnt_q;
		fh_d     = fh_q;
		fhv_d    = fhv_q;
		pay_we   = 1'b0;
		pay_wa   = idx_addr;
		pay_wd   = data_s1;
		vld_we   = 1'b0;
		vld_wa   = idx_addr;
		vld_wd   = 1'b0;
		link_we  = 1'b0;
		link_wd  = fhv_q ? CW'(fh_q) : CW'(POOL_DEPTH);
		status_d = ST_OK;
		slot_d   = '0;
		rd_d     = '0;
		unique case (op_s1)
			OP_ADD, OP_DUP: begin
				if (can_take) begin
					pay_we = 1'b1;
					pay_wa = take_slot;
					if (op_s1 == OP_DUP) begin
						pay_wd = src_live ? pay_rd_q : DATA_WIDTH'(empty_q);
					end
					vld_we = 1'b1;
					vld_wa = take_slot;
					vld_wd = 1'b1;
					cnt_d  = cnt_q + 1'b1;
					slot_d = IDX_W'(take_slot);
					if (fhv_q) begin
						if (link_ok) begin
							fh_d = AW'(link_rd_q);
						end else begin
							fhv_d = 1'b0;
						end
					end else begin
						hw_d = hw_q + 1'b1;
					end
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_FREE: begin
				if (src_live) begin
					link_we = 1'b1;
					vld_we  = 1'b1;
					cnt_d   = cnt_q - 1'b1;
					fh_d    = idx_addr;
					fhv_d   = 1'b1;
				end else begin
					status_d = ST_INVALID;
				end
			end
			OP_READ: begin
				if (src_live) begin
					rd_d = WORD_W'(pay_rd_q);
				end else begin
					rd_d     = empty_q;
					status_d = ST_INVALID;
				end
			end
			OP_WRITE: begin
				if (src_live) begin
					pay_we = 1'b1;
				end else begin
					status_d = ST_INVALID;
				end
			end
			OP_CLEAR: begin
				hw_d  = '0;
				cnt_d = '0;
				fh_d  = '0;
				fhv_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Memory writes in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec && pay_we) begin
			pay_mem[pay_wa] <= pay_wd;
		end
		if (cmd.exec && vld_we) begin
			vld_mem[vld_wa] <= vld_wd;
		end
		if (cmd.exec && link_we) begin
			link_mem[idx_addr] <= link_wd;
		end
	end

	// Pool state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q    <= '0;
			cnt_q   <= '0;
			fh_q    <= '0;
			fhv_q   <= 1'b0;
			empty_q <= '0;
		end else begin
			if (cmd.exec) begin
				hw_q  <= hw_d;
				cnt_q <= cnt_d;
				fh_q  <= fh_d;
				fhv_q <= fhv_d;
			end
			if (cfg_we) begin
				empty_q <= cfg_data;
			end
		end
	end

	// Result registers, loaded in the execute cycle and held until the next one.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= status_d;
			slot_q       <= slot_d;
			read_data_q  <= rd_d;
			live_count_q <= COUNT_W'(cnt_d);
		end
	end

	assign status     = status_q;
	assign slot       = slot_q;
	assign read_data  = read_data_q;
	assign live_count = live_count_q;

`ifndef SYNTHESIS
	// Live slots all lie below the high-water mark.
	a_cnt_hw: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hw_q)
		else $error("live count above high-water mark");

	// The high-water mark never passes the pool depth.
	a_hw_depth: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CW'(POOL_DEPTH))
		else $error("high-water mark beyond pool depth");

	// The free-list head always names a slot that has been used.
	a_fh_used: assert property (@(posedge clk) disable iff (!arst_n)
		fhv_q |-> (32'(fh_q) < 32'(hw_q)))
		else $error("free-list head above high-water mark");
`endif

endmodule
